### src/bcg_pkg.sv
`default_nettype none

package bcg_pkg;

    localparam int VALUE_W   = 32;
    localparam int RAND_W    = 16;
    localparam int ALPHA_W   = 16;
    localparam int STEP_W    = 31;
    localparam int GAMMA_W   = 35;
    localparam int DIFF_W    = 33;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 8'd3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd8192;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] parent_a;
        logic signed [VALUE_W-1:0] parent_b;
        logic [RAND_W-1:0]         rand_u;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] child_a;
        logic signed [VALUE_W-1:0] child_b;
    } out_item_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]        alpha;
        logic signed [VALUE_W-1:0] upper_limit;
        logic signed [VALUE_W-1:0] lower_limit;
        logic [STEP_W-1:0]         step_size;
    } cfg_t;

    // gamma scaled by 2^30 and the parent difference, ready for the blend
    typedef struct packed {
        logic signed [VALUE_W-1:0] x1;
        logic signed [VALUE_W-1:0] x2;
        logic signed [GAMMA_W-1:0] gamma;
        logic signed [DIFF_W-1:0]  diff;
    } blend_item_t;

endpackage

`default_nettype wire

### src/bcg_front.sv
`default_nettype none

module bcg_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bcg_pkg::in_item_t  in_data,
    input  wire logic [15:0]        alpha,
    output logic                    item_valid,
    input  wire logic               item_ready,
    output bcg_pkg::blend_item_t    item
);
    import bcg_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    blend_item_t          item_reg;
    blend_item_t          item_next;
    logic [17:0]          scale;
    logic [33:0]          scaled_u;

    assign in_ready = !valid_reg || item_ready;

    always_comb
    begin
        scale             = 18'd16384 + {1'b0, alpha, 1'b0};
        scaled_u          = 34'(scale) * 34'(in_data.rand_u);
        item_next.x1      = in_data.parent_a;
        item_next.x2      = in_data.parent_b;
        item_next.gamma   = $signed({1'b0, scaled_u}) - $signed({3'b000, alpha, 16'h0000});
        item_next.diff    = $signed({in_data.parent_b[VALUE_W-1], in_data.parent_b})
                          - $signed({in_data.parent_a[VALUE_W-1], in_data.parent_a});
        valid_next        = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### src/bcg_queue.sv
`default_nettype none

module bcg_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire bcg_pkg::blend_item_t push_item,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output bcg_pkg::blend_item_t      pop_item
);
    import bcg_pkg::*;

    blend_item_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### src/bcg_quant.sv
`default_nettype none

// Round to the nearest multiple of the step (halves away from zero), saturate
// and clamp. The division runs one quotient bit per stage.
module bcg_quant (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [bcg_pkg::VALUE_W-1:0] value,
    input  wire bcg_pkg::cfg_t                      cfg,
    output logic signed [bcg_pkg::VALUE_W-1:0]      result
);
    import bcg_pkg::*;

    localparam int STEPS = VALUE_W + 1;

    logic [VALUE_W:0]          num_reg   [STEPS+1];
    logic [VALUE_W-1:0]        rem_reg   [STEPS+1];
    logic [VALUE_W:0]          quo_reg   [STEPS+1];
    logic                      neg_reg   [STEPS+1];
    logic signed [VALUE_W-1:0] val_reg   [STEPS+1];

    logic [VALUE_W-1:0]        divisor;
    logic [VALUE_W-1:0]        mag;
    logic [62:0]               prod_reg;
    logic [62:0]               prod_next;
    logic                      pneg_reg;
    logic signed [VALUE_W-1:0] pval_reg;
    logic signed [VALUE_W-1:0] sat;
    logic signed [VALUE_W-1:0] res_next;
    logic signed [VALUE_W-1:0] res_reg;

    assign divisor = {cfg.step_size, 1'b0};
    assign mag     = value[VALUE_W-1] ? (~value + 1'b1) : value;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= 33'({mag, 1'b0}) + 33'(cfg.step_size);
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            neg_reg[0] <= value[VALUE_W-1];
            val_reg[0] <= value;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        logic [VALUE_W:0] trial;
        logic             fits;
        logic [VALUE_W:0] diff;

        always_comb
        begin
            trial = {rem_reg[k], num_reg[k][VALUE_W]};
            diff  = trial - {1'b0, divisor};
            fits  = (trial >= {1'b0, divisor});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k+1] <= {num_reg[k][VALUE_W-1:0], 1'b0};
                rem_reg[k+1] <= fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
                quo_reg[k+1] <= {quo_reg[k][VALUE_W-1:0], fits};
                neg_reg[k+1] <= neg_reg[k];
                val_reg[k+1] <= val_reg[k];
            end
        end
    end

    assign prod_next = 63'(quo_reg[STEPS][VALUE_W-1:0]) * 63'(cfg.step_size);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            pneg_reg <= neg_reg[STEPS];
            pval_reg <= val_reg[STEPS];
        end
    end

    always_comb
    begin
        if (pneg_reg)
        begin
            sat = (prod_reg > 63'h8000_0000) ? $signed(VALUE_MIN)
                                             : $signed(~prod_reg[VALUE_W-1:0] + 1'b1);
        end
        else
        begin
            sat = (prod_reg > 63'h7FFF_FFFF) ? $signed(VALUE_MAX)
                                             : $signed(prod_reg[VALUE_W-1:0]);
        end
        if (cfg.step_size == '0)
        begin
            sat = pval_reg;
        end
        res_next = sat;
        if (res_next > cfg.upper_limit)
        begin
            res_next = cfg.upper_limit;
        end
        // lower check last: it wins when the limits cross
        if (res_next < cfg.lower_limit)
        begin
            res_next = cfg.lower_limit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

### src/bcg_back.sv
`default_nettype none

module bcg_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire bcg_pkg::blend_item_t item,
    input  wire bcg_pkg::cfg_t        cfg,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bcg_pkg::out_item_t        out_data
);
    import bcg_pkg::*;

    localparam int LAT = 3 + VALUE_W + 4;

    logic                      en;
    logic [LAT-1:0]            vld_reg;
    logic [LAT-1:0]            vld_next;

    logic signed [VALUE_W-1:0] x1_1_reg, x2_1_reg, x1_2_reg, x2_2_reg;
    logic signed [51:0]        pp_lo_reg, pp_hi_reg;
    logic signed [69:0]        prod_reg;
    logic signed [69:0]        rnd_a, rnd_b;
    logic signed [39:0]        sum_a, sum_b;
    logic signed [VALUE_W-1:0] blend_a_reg, blend_b_reg;
    logic signed [VALUE_W-1:0] res_a, res_b;

    function automatic logic signed [VALUE_W-1:0] sat40(input logic signed [39:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v > 40'sh00_7FFF_FFFF)
        begin
            r = $signed(VALUE_MAX);
        end
        else if (v < -40'sh00_8000_0000)
        begin
            r = $signed(VALUE_MIN);
        end
        else
        begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

    // advance the whole line unless the output holds a result not yet taken
    assign en         = out_ready || !vld_reg[LAT-1];
    assign item_ready = en;
    assign vld_next   = {vld_reg[LAT-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        rnd_a = prod_reg + 70'sd536870912;
        rnd_b = -prod_reg + 70'sd536870912;
        sum_a = $signed({{8{x1_2_reg[VALUE_W-1]}}, x1_2_reg}) + rnd_a[69:30];
        sum_b = $signed({{8{x2_2_reg[VALUE_W-1]}}, x2_2_reg}) + rnd_b[69:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_1_reg    <= item.x1;
            x2_1_reg    <= item.x2;
            pp_lo_reg   <= item.gamma * $signed({1'b0, item.diff[15:0]});
            pp_hi_reg   <= item.gamma * $signed(item.diff[32:16]);
            x1_2_reg    <= x1_1_reg;
            x2_2_reg    <= x2_1_reg;
            prod_reg    <= $signed({{2{pp_hi_reg[51]}}, pp_hi_reg, 16'h0000})
                         + $signed({{18{pp_lo_reg[51]}}, pp_lo_reg});
            blend_a_reg <= sat40(sum_a);
            blend_b_reg <= sat40(sum_b);
        end
    end

    bcg_quant u_quant_a (
        .clk    (clk),
        .en     (en),
        .value  (blend_a_reg),
        .cfg    (cfg),
        .result (res_a)
    );

    bcg_quant u_quant_b (
        .clk    (clk),
        .en     (en),
        .value  (blend_b_reg),
        .cfg    (cfg),
        .result (res_b)
    );

    assign out_valid        = vld_reg[LAT-1];
    assign out_data.child_a = res_a;
    assign out_data.child_b = res_b;

endmodule

`default_nettype wire

### src/blend_crossover_gene.sv
`default_nettype none

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | parent_a, parent_b, rand_u
// out     | output    | out_valid / out_ready | child_a, child_b
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle sustained while out_ready holds. Each request passes
// the front register, which loads at the accept edge, then the queue, then
// the 39 back registers, 33 of them the one-bit stages of the rounding
// divider. A stalled output freezes the back pipeline; the two-entry queue
// and front stage keep taking requests until they fill.
// Reset clears all control state and loads the register defaults.
module blend_crossover_gene (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire bcg_pkg::in_item_t                in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output bcg_pkg::out_item_t                    out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bcg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data
);
    import bcg_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        f_valid, f_ready, q_valid, q_ready;
    blend_item_t f_item, q_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ALPHA: cfg_next.alpha       = cfg_data[ALPHA_W-1:0];
                REG_UPPER: cfg_next.upper_limit = $signed(cfg_data);
                REG_LOWER: cfg_next.lower_limit = $signed(cfg_data);
                REG_STEP:  cfg_next.step_size   = cfg_data[STEP_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha       <= ALPHA_RESET;
            cfg_reg.upper_limit <= $signed(VALUE_MAX);
            cfg_reg.lower_limit <= $signed(VALUE_MIN);
            cfg_reg.step_size   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bcg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .alpha      (cfg_reg.alpha),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    bcg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    bcg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .cfg        (cfg_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

### tb/tb_blend_crossover_gene.sv
`timescale 1ns / 100ps

module tb_blend_crossover_gene;
    import bcg_pkg::*;

    localparam int LATENCY = 41;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    blend_crossover_gene DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // register shadow
    logic [ALPHA_W-1:0] sh_alpha;
    logic signed [VALUE_W-1:0] sh_upper;
    logic signed [VALUE_W-1:0] sh_lower;
    logic [STEP_W-1:0] sh_step;

    out_item_t children_q[$];
    int errors;
    bit long_hold;
    bit stall_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic signed [63:0] saturate32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor((g*d + 2^29) / 2^30); product fits in 128 bits
    function automatic logic signed [63:0] blend_offset(logic signed [63:0] g,
                                                        logic signed [63:0] d);
        logic signed [127:0] prod;
        prod = 128'(g) * 128'(d) + (128'sd1 <<< 29);
        return 64'(prod >>> 30);
    endfunction

    function automatic logic signed [31:0] shape_child(logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] s;
        bit neg;
        v = saturate32(v);
        if (sh_step != '0)
        begin
            s = 64'(sh_step);
            neg = v < 0;
            mag = neg ? 64'(-v) : 64'(v);
            q = (2 * mag + s) / (2 * s);
            v = neg ? -$signed(q * s) : $signed(q * s);
            v = saturate32(v);
        end
        if (v > 64'(sh_upper))
            v = 64'(sh_upper);
        if (v < 64'(sh_lower))
            v = 64'(sh_lower);
        return v[31:0];
    endfunction

    function automatic out_item_t blend_children(in_item_t it);
        out_item_t r;
        logic signed [63:0] x1;
        logic signed [63:0] x2;
        logic signed [63:0] g;
        x1 = 64'(it.parent_a);
        x2 = 64'(it.parent_b);
        g = (64'sd16384 + 2 * $signed({48'd0, sh_alpha})) * $signed({48'd0, it.rand_u})
            - $signed({48'd0, sh_alpha}) * 64'sd65536;
        r.child_a = shape_child(x1 + blend_offset(g, x2 - x1));
        r.child_b = shape_child(x2 + blend_offset(g, x1 - x2));
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_ALPHA: sh_alpha = val[ALPHA_W-1:0];
            REG_UPPER: sh_upper = val;
            REG_LOWER: sh_lower = val;
            REG_STEP:  sh_step = val[STEP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one request; golden value checked when has_gold is set
    task automatic send_pair(in_item_t it, bit has_gold, out_item_t gold);
        out_item_t pred;
        pred = blend_children(it);
        if (has_gold && pred !== gold)
        begin
            $display("%0t table mismatch: expected %h actual %h", $time, gold, pred);
            errors++;
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        children_q.push_back(pred);
        @(negedge clk);
    endtask

    task automatic drain();
        while (children_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_gene();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_burst(int count);
        in_item_t it;
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && count > 0)
            begin
                it.parent_a = rand_gene();
                it.parent_b = ($urandom_range(0, 3) == 0) ? it.parent_a : rand_gene();
                it.rand_u = ($urandom_range(0, 7) == 0) ?
                            ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : 16'($urandom());
                send_pair(it, 1'b0, '0);
                burst--;
                count--;
            end
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    typedef struct {
        in_item_t it;
        bit has_gold;
        out_item_t gold;
    } pair_row_t;

    // receiver stalls on its own pattern, with one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (150) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (stall_on)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (children_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = children_q.pop_front();
                if (out_data.child_a !== e.child_a)
                begin
                    $display("%0t child_a: expected %h actual %h", $time, e.child_a,
                             out_data.child_a);
                    errors++;
                end
                if (out_data.child_b !== e.child_b)
                begin
                    $display("%0t child_b: expected %h actual %h", $time, e.child_b,
                             out_data.child_b);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        pair_row_t rows[$];
        pair_row_t r;
        errors = 0;
        long_hold = 1'b0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sh_alpha = ALPHA_RESET;
        sh_upper = VALUE_MAX;
        sh_lower = VALUE_MIN;
        sh_step = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table at reset settings
        r = '{'{32'sd0, 32'sd0, 16'd0}, 1'b1, '{32'sd0, 32'sd0}}; rows.push_back(r);
        r = '{'{32'h0001_0000, 32'h0001_0000, 16'hFFFF}, 1'b1,
              '{32'h0001_0000, 32'h0001_0000}}; rows.push_back(r);
        r = '{'{VALUE_MAX, VALUE_MAX, 16'h1234}, 1'b1, '{VALUE_MAX, VALUE_MAX}};
        rows.push_back(r);
        r = '{'{VALUE_MIN, VALUE_MIN, 16'h8000}, 1'b1, '{VALUE_MIN, VALUE_MIN}};
        rows.push_back(r);
        r = '{'{VALUE_MAX, VALUE_MIN, 16'h0000}, 1'b0, '0}; rows.push_back(r);
        r = '{'{VALUE_MIN, VALUE_MAX, 16'hFFFF}, 1'b0, '0}; rows.push_back(r);
        r = '{'{32'h0001_0000, 32'hFFFF_0000, 16'h4000}, 1'b0, '0}; rows.push_back(r);
        r = '{'{32'h1234_5678, 32'h8765_4321, 16'hAAAA}, 1'b0, '0}; rows.push_back(r);
        foreach (rows[i])
            send_pair(rows[i].it, rows[i].has_gold, rows[i].gold);
        in_valid <= 1'b0;
        drain();

        // quantization, crossed limits, ignored index, high register bits
        write_reg(REG_STEP, 32'hFFFF_0000);
        write_reg(REG_ALPHA, 32'hFFFF_0000);
        write_reg(8'd7, 32'h1234_5678);
        write_reg(REG_UPPER, 32'h0002_0000);
        write_reg(REG_LOWER, 32'h0005_0000);
        rows.delete();
        r = '{'{32'h0010_0000, 32'h0010_0000, 16'h0}, 1'b1, '{32'h0005_0000, 32'h0005_0000}};
        rows.push_back(r);
        r = '{'{32'hFFF0_0000, 32'h0000_8000, 16'h7FFF}, 1'b0, '0}; rows.push_back(r);
        r = '{'{32'h0000_8000, 32'h0000_8000, 16'h1}, 1'b0, '0}; rows.push_back(r);
        foreach (rows[i])
            send_pair(rows[i].it, rows[i].has_gold, rows[i].gold);
        in_valid <= 1'b0;
        drain();

        stall_on = 1'b1;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_ALPHA, 16'd0); write_reg(REG_STEP, 0);
                   write_reg(REG_UPPER, VALUE_MAX); write_reg(REG_LOWER, VALUE_MIN); end
                1: begin write_reg(REG_ALPHA, 16'hFFFF); write_reg(REG_STEP, 1); end
                2: begin write_reg(REG_ALPHA, ALPHA_RESET); write_reg(REG_STEP, 32'h0000_8000);
                   write_reg(REG_UPPER, 32'h0100_0000); write_reg(REG_LOWER, 32'hFF00_0000); end
                3: begin write_reg(REG_STEP, 31'h7FFF_FFFF); write_reg(REG_ALPHA, 16'h4000);
                   write_reg(REG_UPPER, VALUE_MAX); write_reg(REG_LOWER, VALUE_MIN); end
                4: begin write_reg(REG_STEP, $urandom_range(1, 32'h0003_0000));
                   write_reg(REG_ALPHA, $urandom());
                   write_reg(REG_UPPER, 32'h0000_0000); write_reg(REG_LOWER, 32'h0001_0000); end
                default: begin write_reg(REG_STEP, 0); write_reg(REG_ALPHA, $urandom());
                   write_reg(REG_UPPER, $urandom_range(0, 32'h7000_0000));
                   write_reg(REG_LOWER, -$urandom_range(0, 32'h7000_0000)); end
            endcase
            if (phase == 2)
                long_hold = 1'b1;
            random_burst(65);
            drain();
            stall_on = (phase % 2 == 0);
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
src/bcg_pkg.sv
src/bcg_front.sv
src/bcg_queue.sv
src/bcg_quant.sv
src/bcg_back.sv
src/blend_crossover_gene.sv
tb/tb_blend_crossover_gene.sv
